>>> sv/hsfd_pkg.sv
// Package of the humidity sensor frame decoder: item types, frame byte
// positions, CRC and conversion constants, and the byte-wide CRC-8 step.
// Depends on nothing; every other file of the block uses it.
package hsfd_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_start;
	} in_item_t;

	typedef struct packed {
		logic signed [11:0] temperature_tenths;
		logic        [9:0]  humidity_tenths;
		logic               temperature_crc_ok;
		logic               humidity_crc_ok;
	} out_item_t;

	// Raw words of one complete frame, as handed to the conversion stages.
	typedef struct packed {
		logic [15:0] temp_word;
		logic [15:0] hum_word;
		logic        temp_ok;
		logic        hum_ok;
	} raw_t;

	// Position of a byte within the frame.
	localparam logic [2:0] POS_T_MSB = 3'd0;
	localparam logic [2:0] POS_T_LSB = 3'd1;
	localparam logic [2:0] POS_T_CRC = 3'd2;
	localparam logic [2:0] POS_H_MSB = 3'd3;
	localparam logic [2:0] POS_H_LSB = 3'd4;
	localparam logic [2:0] POS_H_CRC = 3'd5;

	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	// Conversion constants: T scale 1750, offset 450 * 65535, H scale 1000.
	localparam logic [10:0] TEMP_SCALE  = 11'd1750;
	localparam logic [9:0]  HUM_SCALE   = 10'd1000;
	localparam logic [26:0] TEMP_OFFSET = 27'd29490750;
	localparam logic signed [12:0] TEMP_BIAS = 13'sd450;

	// One byte through CRC-8, MSB first, no reflection.
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] v;
		v = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (v[7]) begin
				v = {v[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				v = {v[6:0], 1'b0};
			end
		end
		return v;
	endfunction

endpackage

>>> sv/hsfd_if.sv
// Valid/ready channel interfaces of the humidity sensor frame decoder.
// Depends on hsfd_pkg for the item types.
interface hsfd_in_if;
	logic                valid;
	logic                ready;
	hsfd_pkg::in_item_t  data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface hsfd_out_if;
	logic                valid;
	logic                ready;
	hsfd_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> sv/humidity_sensor_frame_decoder_unit.sv
// Top level of the humidity sensor frame decoder.
// Depends on hsfd_pkg, hsfd_if, hsfd_assembler and hsfd_convert.
//
// This block takes the six bytes of a sensor measurement frame, one item per
// clock cycle on rx while rx.ready is high: temperature MSB, LSB and CRC, then
// humidity MSB, LSB and CRC. Each word is checked with CRC-8 (polynomial 0x31,
// initial value 0xFF), and the sixth byte produces one item on result with both
// check flags, the temperature in tenths of a degree Celsius and the humidity
// in tenths of a percent, truncated toward zero. A byte carrying frame_start
// always begins a new frame; after the sixth byte the next frame may follow
// without it. A new byte can be taken in every cycle while rx.ready is high.
// The result passes through the frame register, the register of the constant
// multipliers, and the output register, which the division by 65535 feeds. The
// three registers form an elastic pipeline, so bytes keep flowing while a
// result waits to be taken, until the pipeline holds three results.
module humidity_sensor_frame_decoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	hsfd_in_if.sink    rx,
	hsfd_out_if.source result
);

	hsfd_pkg::raw_t raw_s1;
	logic           raw_valid_s1;
	logic           raw_ready;

	hsfd_assembler u_assembler (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx           (rx),
		.raw_s1       (raw_s1),
		.raw_valid_s1 (raw_valid_s1),
		.raw_ready    (raw_ready)
	);

	hsfd_convert u_convert (
		.clk          (clk),
		.arst_n       (arst_n),
		.raw_s1       (raw_s1),
		.raw_valid_s1 (raw_valid_s1),
		.raw_ready    (raw_ready),
		.result       (result)
	);

	// A consumer that takes results never stalls the byte stream.
	a_ready_through: assert property (@(posedge clk) disable iff (!arst_n)
		result.ready |-> rx.ready)
		else $error("byte input stalled while result output was ready");

	// Converted values stay within the sensor range.
	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.data.temperature_tenths >= -12'sd450 &&
			result.data.temperature_tenths <= 12'sd1300))
		else $error("temperature result out of range");

	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.data.humidity_tenths <= 10'd1000))
		else $error("humidity result out of range");

endmodule

>>> sv/hsfd_assembler.sv
// Frame assembler: tracks the byte position, runs the CRC over each word and
// registers the raw words of a finished frame. Depends on hsfd_pkg, hsfd_if.
module hsfd_assembler (
	input  logic          clk,
	input  logic          arst_n,
	hsfd_in_if.sink       rx,
	output hsfd_pkg::raw_t raw_s1,
	output logic          raw_valid_s1,
	input  logic          raw_ready
);

	logic [2:0]  pos_q;
	logic [7:0]  crc_q;
	logic [15:0] temp_word_q;
	logic [7:0]  hum_hi_q;
	logic [7:0]  hum_lo_q;
	logic        temp_ok_q;

	logic        accept;
	logic [2:0]  pos_eff;
	logic [7:0]  crc_eff;
	logic [7:0]  crc_next;
	logic [7:0]  b;

	assign rx.ready = !raw_valid_s1 || raw_ready;
	assign accept   = rx.valid && rx.ready;
	assign b        = rx.data.data_byte;

	// A frame start drops any partial frame.
	assign pos_eff  = rx.data.frame_start ? hsfd_pkg::POS_T_MSB : pos_q;
	assign crc_eff  = rx.data.frame_start ? hsfd_pkg::CRC_INIT : crc_q;
	assign crc_next = hsfd_pkg::crc8_byte(crc_eff, b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= hsfd_pkg::POS_T_MSB;
			crc_q        <= hsfd_pkg::CRC_INIT;
			temp_word_q  <= '0;
			hum_hi_q     <= '0;
			hum_lo_q     <= '0;
			temp_ok_q    <= 1'b0;
			raw_valid_s1 <= 1'b0;
		end else begin
			// The frame register fills with the last byte and empties when taken.
			if (accept && pos_eff == hsfd_pkg::POS_H_CRC) begin
				raw_valid_s1 <= 1'b1;
			end else if (raw_ready) begin
				raw_valid_s1 <= 1'b0;
			end
			if (accept) begin
				case (pos_eff)
					hsfd_pkg::POS_T_MSB: begin
						crc_q             <= crc_next;
						temp_word_q[15:8] <= b;
						pos_q             <= hsfd_pkg::POS_T_LSB;
					end
					hsfd_pkg::POS_T_LSB: begin
						crc_q            <= crc_next;
						temp_word_q[7:0] <= b;
						pos_q            <= hsfd_pkg::POS_T_CRC;
					end
					hsfd_pkg::POS_T_CRC: begin
						temp_ok_q <= (crc_eff == b);
						crc_q     <= hsfd_pkg::CRC_INIT;
						pos_q     <= hsfd_pkg::POS_H_MSB;
					end
					hsfd_pkg::POS_H_MSB: begin
						crc_q    <= crc_next;
						hum_hi_q <= b;
						pos_q    <= hsfd_pkg::POS_H_LSB;
					end
					hsfd_pkg::POS_H_LSB: begin
						crc_q    <= crc_next;
						hum_lo_q <= b;
						pos_q    <= hsfd_pkg::POS_H_CRC;
					end
					hsfd_pkg::POS_H_CRC: begin
						crc_q        <= hsfd_pkg::CRC_INIT;
						pos_q        <= hsfd_pkg::POS_T_MSB;
					end
					default: begin
						crc_q <= hsfd_pkg::CRC_INIT;
						pos_q <= hsfd_pkg::POS_T_MSB;
					end
				endcase
			end
		end
	end

	// Payload of the frame register; loaded only with the last byte.
	always_ff @(posedge clk) begin
		if (accept && pos_eff == hsfd_pkg::POS_H_CRC) begin
			raw_s1.temp_word <= temp_word_q;
			raw_s1.hum_word  <= {hum_hi_q, hum_lo_q};
			raw_s1.temp_ok   <= temp_ok_q;
			raw_s1.hum_ok    <= (crc_eff == b);
		end
	end

endmodule

>>> sv/hsfd_convert.sv
// Conversion pipeline: constant multiplies, then division by 65535 with
// truncation toward zero, into the result register. Depends on hsfd_pkg, hsfd_if.
module hsfd_convert (
	input  logic           clk,
	input  logic           arst_n,
	input  hsfd_pkg::raw_t raw_s1,
	input  logic           raw_valid_s1,
	output logic           raw_ready,
	hsfd_out_if.source     result
);

	logic [26:0] temp_prod_s2;
	logic [25:0] hum_prod_s2;
	logic        temp_ok_s2;
	logic        hum_ok_s2;
	logic        valid_s2;
	logic        valid_s3;

	logic        ready_s3;
	logic        ready_s2;

	logic [27:0] temp_sum;
	logic [10:0] temp_q;
	logic [26:0] temp_back;
	logic        temp_neg;
	logic        temp_ceil;
	logic signed [12:0] temp_val;
	logic [26:0] hum_sum;
	logic [9:0]  hum_q;

	assign ready_s3  = !valid_s3 || result.ready;
	assign ready_s2  = !valid_s2 || ready_s3;
	assign raw_ready = ready_s2;
	assign result.valid = valid_s3;

	// x / 65535 = (x + (x >> 16) + 1) >> 16 for quotients up to 65536.
	assign temp_sum  = {1'b0, temp_prod_s2} + 28'(temp_prod_s2[26:16]) + 28'd1;
	assign temp_q    = temp_sum[26:16];
	assign temp_back = {temp_q, 16'd0} - 27'(temp_q);
	// Below the offset the numerator is negative and truncation rounds up.
	assign temp_neg  = temp_prod_s2 < hsfd_pkg::TEMP_OFFSET;
	assign temp_ceil = temp_neg && (temp_back != temp_prod_s2);
	assign temp_val  = $signed({2'b00, temp_q}) + $signed({12'd0, temp_ceil})
		- hsfd_pkg::TEMP_BIAS;

	assign hum_sum = {1'b0, hum_prod_s2} + 27'(hum_prod_s2[25:16]) + 27'd1;
	assign hum_q   = hum_sum[25:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s2) begin
				valid_s2 <= raw_valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && raw_valid_s1) begin
			temp_prod_s2 <= 27'(raw_s1.temp_word) * hsfd_pkg::TEMP_SCALE;
			hum_prod_s2  <= 26'(raw_s1.hum_word) * hsfd_pkg::HUM_SCALE;
			temp_ok_s2   <= raw_s1.temp_ok;
			hum_ok_s2    <= raw_s1.hum_ok;
		end
		if (ready_s3 && valid_s2) begin
			result.data.temperature_tenths <= temp_val[11:0];
			result.data.humidity_tenths    <= hum_q;
			result.data.temperature_crc_ok <= temp_ok_s2;
			result.data.humidity_crc_ok    <= hum_ok_s2;
		end
	end

endmodule
